### sv/dpd_pkg.sv
// Shared types, constants and register codes for the double pulse detector.
package dpd_pkg;

    localparam int NUM_CHANNELS_DEF = 4;

    localparam int CH_W        = 2;
    localparam int TIME_W      = 32;
    localparam int LIM_W       = 16;
    localparam int GLITCH_W    = 8;
    localparam int PHASE_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_FIRST  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HELD   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PAUSE  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SECOND = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GLITCH_LIMIT = 3'd5;

    localparam logic [LIM_W-1:0]    FIRST_MIN_RST    = 16'd40;
    localparam logic [LIM_W-1:0]    SECOND_MIN_RST   = 16'd50;
    localparam logic [LIM_W-1:0]    PAUSE_MIN_RST    = 16'd50;
    localparam logic [LIM_W-1:0]    PAUSE_MAX_RST    = 16'd1500;
    localparam logic [LIM_W-1:0]    TIMEOUT_RST      = 16'd1000;
    localparam logic [GLITCH_W-1:0] GLITCH_LIMIT_RST = 8'd20;

    localparam logic [GLITCH_W-1:0] GLITCH_MAX = 8'hFF;

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic [TIME_W-1:0]   timer;
        logic [TIME_W-1:0]   pause_start;
        logic [GLITCH_W-1:0] glitch;
    } chan_state_t;

    typedef struct packed {
        logic [LIM_W-1:0]    first_min;
        logic [LIM_W-1:0]    second_min;
        logic [LIM_W-1:0]    pause_min;
        logic [LIM_W-1:0]    pause_max;
        logic [LIM_W-1:0]    timeout;
        logic [GLITCH_W-1:0] glitch_limit;
    } cfg_t;

    typedef struct packed {
        logic first_ok;
        logic double_ok;
    } step_flags_t;

endpackage

### sv/dpd_state_mem.sv
// Per-channel state memory with registered read and write-to-read forwarding.
module dpd_state_mem #(
    parameter int NUM_CHANNELS = dpd_pkg::NUM_CHANNELS_DEF,
    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  dpd_pkg::chan_state_t  wr_data,
    output dpd_pkg::chan_state_t  rd_data
);

    dpd_pkg::chan_state_t mem [NUM_CHANNELS];
    dpd_pkg::chan_state_t rdata_reg;
    dpd_pkg::chan_state_t fwd_data_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic [ADDR_W-1:0]     fwd_addr_reg;
    logic                  fwd_valid_reg;
    logic                  rvld_reg;
    logic [NUM_CHANNELS-1:0] vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rvld_reg      <= 1'b0;
            fwd_valid_reg <= 1'b0;
            rd_addr_reg   <= '0;
            fwd_addr_reg  <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rvld_reg    <= vld_reg[rd_addr];
                rd_addr_reg <= rd_addr;
            end
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
                fwd_valid_reg    <= 1'b1;
                fwd_addr_reg     <= wr_addr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // last write always matches memory contents, so it may override a stale read
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg))
        begin
            rd_data = fwd_data_reg;
        end
        else if (rvld_reg)
        begin
            rd_data = rdata_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

### sv/dpd_step.sv
// Next-state logic of one channel detector for one sample.
module dpd_step (
    input  dpd_pkg::chan_state_t              cur,
    input  logic                              hi,
    input  logic [dpd_pkg::TIME_W-1:0]        now,
    input  dpd_pkg::cfg_t                     cfg,
    input  logic [dpd_pkg::TIME_W-1:0]        marker_in,
    output dpd_pkg::chan_state_t              nxt,
    output dpd_pkg::step_flags_t              flags,
    output logic [dpd_pkg::TIME_W-1:0]        marker_out
);

    localparam logic [1:0] TSRC_CUR  = 2'd0;
    localparam logic [1:0] TSRC_NOW  = 2'd1;
    localparam logic [1:0] TSRC_ZERO = 2'd2;

    logic [dpd_pkg::PHASE_W-1:0]  ph;
    logic [dpd_pkg::TIME_W-1:0]   timer;
    logic [1:0]                   tsrc;
    logic [dpd_pkg::TIME_W-1:0]   pstart;
    logic                         pstart_now;
    logic [dpd_pkg::GLITCH_W-1:0] glitch;
    logic [dpd_pkg::TIME_W-1:0]   el_cur;
    logic [dpd_pkg::TIME_W-1:0]   el_hold_cur;
    logic                         gt_timeout_cur;
    logic                         gt_timeout_zero;
    logic                         gt_first_cur;
    logic                         gt_first_zero;
    logic                         gt_pause_cur;
    logic                         gt_pause_zero;
    logic                         gt_second_cur;
    logic                         gt_second_zero;
    logic                         hold_cur;
    logic                         hold_now;
    logic                         first_ok;
    logic                         double_ok;

    // timer is always the stored value, now or zero, so all compares run in parallel
    assign el_cur          = now - cur.timer;
    assign el_hold_cur     = now - cur.pause_start;
    assign gt_timeout_cur  = el_cur > dpd_pkg::TIME_W'(cfg.timeout);
    assign gt_timeout_zero = now > dpd_pkg::TIME_W'(cfg.timeout);
    assign gt_first_cur    = el_cur > dpd_pkg::TIME_W'(cfg.first_min);
    assign gt_first_zero   = now > dpd_pkg::TIME_W'(cfg.first_min);
    assign gt_pause_cur    = el_cur > dpd_pkg::TIME_W'(cfg.pause_min);
    assign gt_pause_zero   = now > dpd_pkg::TIME_W'(cfg.pause_min);
    assign gt_second_cur   = el_cur > dpd_pkg::TIME_W'(cfg.second_min);
    assign gt_second_zero  = now > dpd_pkg::TIME_W'(cfg.second_min);
    assign hold_cur        = el_hold_cur < dpd_pkg::TIME_W'(cfg.pause_max);
    assign hold_now        = cfg.pause_max != '0;

    function automatic logic past_limit(input logic [1:0] src, input logic gt_cur,
                                        input logic gt_zero);
        logic res;
        case (src)
            TSRC_CUR:  res = gt_cur;
            TSRC_ZERO: res = gt_zero;
            default:   res = 1'b0;
        endcase
        return res;
    endfunction

    always_comb
    begin
        ph         = cur.phase;
        timer      = cur.timer;
        tsrc       = TSRC_CUR;
        pstart     = cur.pause_start;
        pstart_now = 1'b0;
        glitch     = cur.glitch;
        first_ok   = 1'b0;
        double_ok  = 1'b0;

        if (hi && ph == dpd_pkg::PH_IDLE)
        begin
            timer  = now;
            tsrc   = TSRC_NOW;
            ph     = dpd_pkg::PH_FIRST;
            glitch = '0;
        end

        if (past_limit(tsrc, gt_timeout_cur, gt_timeout_zero))
        begin
            timer  = '0;
            tsrc   = TSRC_ZERO;
            ph     = dpd_pkg::PH_IDLE;
            glitch = '0;
        end

        if ((ph == dpd_pkg::PH_FIRST || ph == dpd_pkg::PH_SECOND) && !hi
            && glitch != dpd_pkg::GLITCH_MAX)
        begin
            glitch = glitch + 8'd1;
        end

        if (hi && ph == dpd_pkg::PH_FIRST && past_limit(tsrc, gt_first_cur, gt_first_zero)
            && glitch < cfg.glitch_limit)
        begin
            ph       = dpd_pkg::PH_HELD;
            glitch   = '0;
            timer    = now;
            tsrc     = TSRC_NOW;
            first_ok = 1'b1;
        end

        if (hi && ph == dpd_pkg::PH_HELD)
        begin
            timer = now;
            tsrc  = TSRC_NOW;
        end

        if (!hi && ph == dpd_pkg::PH_HELD && past_limit(tsrc, gt_pause_cur, gt_pause_zero))
        begin
            ph         = dpd_pkg::PH_PAUSE;
            timer      = now;
            tsrc       = TSRC_NOW;
            pstart     = now;
            pstart_now = 1'b1;
        end

        if (!hi && ph == dpd_pkg::PH_PAUSE && (pstart_now ? hold_now : hold_cur))
        begin
            timer = now;
            tsrc  = TSRC_NOW;
        end

        if (hi && ph == dpd_pkg::PH_PAUSE)
        begin
            timer  = now;
            tsrc   = TSRC_NOW;
            ph     = dpd_pkg::PH_SECOND;
            glitch = '0;
        end

        if (hi && ph == dpd_pkg::PH_SECOND && past_limit(tsrc, gt_second_cur, gt_second_zero)
            && glitch < cfg.glitch_limit)
        begin
            glitch    = '0;
            timer     = '0;
            ph        = dpd_pkg::PH_IDLE;
            double_ok = 1'b1;
        end
    end

    assign nxt.phase       = ph;
    assign nxt.timer       = timer;
    assign nxt.pause_start = pstart;
    assign nxt.glitch      = glitch;
    assign flags.first_ok  = first_ok;
    assign flags.double_ok = double_ok;
    assign marker_out      = first_ok ? now : marker_in;

endmodule

### sv/double_pulse_detector.sv
// Top level: sample stream in, per-channel detector state memory, result stream out.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+------------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | channel, sample, now_ms
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | out_channel, flags, marker_ms, phase
//  cfg       | in  | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
//  One sample per cycle sustained while the output is not stalled; an input transaction
//  passes the memory read stage, then update/writeback into the output register.
//  Back-to-back samples on the same channel use the writeback forwarding path.
//  Reset clears all channel state at once through per-entry valid bits; no sweep.
//  A stalled output holds the update stage; input stalls only when both stages are full.
module double_pulse_detector #(
    parameter int NUM_CHANNELS = dpd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [1:0] channel, [2] sample, [34:3] now_ms, [39:35] zero
    input  logic [dpd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] out_channel, [2] first_confirmed, [3] double_detected,
    // [35:4] marker_ms, [38:36] phase, [39] zero
    output logic [dpd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EXT_W  = ADDR_W + dpd_pkg::CH_W;

    dpd_pkg::cfg_t                     cfg_reg;
    logic [dpd_pkg::CH_W-1:0]          in_ch;
    logic                              in_hi;
    logic [dpd_pkg::TIME_W-1:0]        in_now;
    logic [EXT_W-1:0]                  in_ch_ext;
    logic [ADDR_W-1:0]                 in_addr;
    logic                              in_range;
    logic                              accept;

    logic                              s1_valid_reg;
    logic [dpd_pkg::CH_W-1:0]          s1_ch_reg;
    logic                              s1_hi_reg;
    logic [dpd_pkg::TIME_W-1:0]        s1_now_reg;
    logic [ADDR_W-1:0]                 s1_addr_reg;
    logic                              s1_range_reg;
    logic                              s1_adv;

    dpd_pkg::chan_state_t              cur_state;
    dpd_pkg::chan_state_t              nxt_state;
    dpd_pkg::step_flags_t              flags;
    logic [dpd_pkg::TIME_W-1:0]        marker_reg;
    logic [dpd_pkg::TIME_W-1:0]        marker_next;

    logic                              out_valid_reg;
    logic [dpd_pkg::CH_W-1:0]          out_ch_reg;
    logic                              out_first_reg;
    logic                              out_double_reg;
    logic [dpd_pkg::TIME_W-1:0]        out_marker_reg;
    logic [dpd_pkg::PHASE_W-1:0]       out_phase_reg;

    assign in_ch     = s_axis_tdata[1:0];
    assign in_hi     = s_axis_tdata[2];
    assign in_now    = s_axis_tdata[34:3];
    assign in_ch_ext = EXT_W'(in_ch);
    assign in_addr   = in_ch_ext[ADDR_W-1:0];
    assign in_range  = in_ch_ext < EXT_W'(NUM_CHANNELS);

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_min    <= dpd_pkg::FIRST_MIN_RST;
            cfg_reg.second_min   <= dpd_pkg::SECOND_MIN_RST;
            cfg_reg.pause_min    <= dpd_pkg::PAUSE_MIN_RST;
            cfg_reg.pause_max    <= dpd_pkg::PAUSE_MAX_RST;
            cfg_reg.timeout      <= dpd_pkg::TIMEOUT_RST;
            cfg_reg.glitch_limit <= dpd_pkg::GLITCH_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dpd_pkg::REG_FIRST_MIN:    cfg_reg.first_min    <= cfg_data;
                dpd_pkg::REG_SECOND_MIN:   cfg_reg.second_min   <= cfg_data;
                dpd_pkg::REG_PAUSE_MIN:    cfg_reg.pause_min    <= cfg_data;
                dpd_pkg::REG_PAUSE_MAX:    cfg_reg.pause_max    <= cfg_data;
                dpd_pkg::REG_TIMEOUT:      cfg_reg.timeout      <= cfg_data;
                dpd_pkg::REG_GLITCH_LIMIT: cfg_reg.glitch_limit <= cfg_data[dpd_pkg::GLITCH_W-1:0];
                default:                   ;
            endcase
        end
    end

    dpd_state_mem #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_range),
        .rd_addr (in_addr),
        .wr_en   (s1_adv && s1_range_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (nxt_state),
        .rd_data (cur_state)
    );

    dpd_step u_step (
        .cur        (cur_state),
        .hi         (s1_hi_reg),
        .now        (s1_now_reg),
        .cfg        (cfg_reg),
        .marker_in  (marker_reg),
        .nxt        (nxt_state),
        .flags      (flags),
        .marker_out (marker_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            marker_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_adv && s1_range_reg)
            begin
                marker_reg <= marker_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg    <= in_ch;
            s1_hi_reg    <= in_hi;
            s1_now_reg   <= in_now;
            s1_addr_reg  <= in_addr;
            s1_range_reg <= in_range;
        end
        if (s1_adv)
        begin
            out_ch_reg     <= s1_ch_reg;
            out_first_reg  <= s1_range_reg && flags.first_ok;
            out_double_reg <= s1_range_reg && flags.double_ok;
            out_marker_reg <= s1_range_reg ? marker_next : marker_reg;
            out_phase_reg  <= s1_range_reg ? nxt_state.phase : dpd_pkg::PH_IDLE;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_phase_reg, out_marker_reg,
                            out_double_reg, out_first_reg, out_ch_reg};

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_first_reg && out_double_reg))
        else $error("first and double flagged together");

    a_double_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_double_reg) |-> (out_phase_reg == dpd_pkg::PH_IDLE))
        else $error("double detection left channel busy");

    a_first_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_first_reg) |-> (out_phase_reg == dpd_pkg::PH_HELD))
        else $error("first confirmation not in held phase");

    a_marker_update: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_range_reg && flags.first_ok) |=> (marker_reg == $past(s1_now_reg)))
        else $error("marker not set to confirmation time");

endmodule

### sim/tb_double_pulse_detector.sv
`timescale 1ns / 1ps
// Self-checking testbench for double_pulse_detector: directed and random sample streams.
module tb_double_pulse_detector;

    localparam int N_CH        = dpd_pkg::NUM_CHANNELS_DEF;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_LEN    = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;
    localparam int STORM_LEN   = 300;

    localparam logic [dpd_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [dpd_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [dpd_pkg::TIME_W-1:0] now;
        logic                       hi;
        logic [dpd_pkg::CH_W-1:0]   ch;
    } sample_t;

    typedef struct packed {
        logic [dpd_pkg::PHASE_W-1:0] phase;
        logic [dpd_pkg::TIME_W-1:0]  marker;
        logic                        dbl;
        logic                        first;
        logic [dpd_pkg::CH_W-1:0]    ch;
    } pulse_result_t;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [dpd_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [dpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [dpd_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [dpd_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

    double_pulse_detector u_top (.*);

    always #6 clk = ~clk;

    // predictor copy of limits and per-channel state
    logic [dpd_pkg::LIM_W-1:0]    lim_first;
    logic [dpd_pkg::LIM_W-1:0]    lim_second;
    logic [dpd_pkg::LIM_W-1:0]    lim_pause_min;
    logic [dpd_pkg::LIM_W-1:0]    lim_pause_max;
    logic [dpd_pkg::LIM_W-1:0]    lim_timeout;
    logic [dpd_pkg::GLITCH_W-1:0] lim_glitch;
    logic [dpd_pkg::PHASE_W-1:0]  ch_phase       [N_CH];
    logic [dpd_pkg::TIME_W-1:0]   ch_timer       [N_CH];
    logic [dpd_pkg::TIME_W-1:0]   ch_pause_start [N_CH];
    logic [dpd_pkg::GLITCH_W-1:0] ch_glitch      [N_CH];
    logic [dpd_pkg::TIME_W-1:0]   marker_ms;

    sample_t       pending_samples[$];
    pulse_result_t expected_results[$];

    int          samples_sent   = 0;
    int          samples_queued = 0;
    int          err_count      = 0;
    int          cycles         = 0;
    int          hold_cnt       = 0;
    int          tx_wait        = 0;
    int          rx_wait        = 0;
    bit          in_busy        = 1'b0;
    bit          stall_en       = 1'b1;
    bit          in_fire_q      = 1'b0;
    bit          out_fire_q     = 1'b0;
    logic [dpd_pkg::TIME_W-1:0] clock_ms = '0;

    function automatic logic [dpd_pkg::TIME_W-1:0] since(
        input logic [dpd_pkg::TIME_W-1:0] now_t, start_t);
        return now_t - start_t;
    endfunction

    task automatic reset_model();
        lim_first     = dpd_pkg::FIRST_MIN_RST;
        lim_second    = dpd_pkg::SECOND_MIN_RST;
        lim_pause_min = dpd_pkg::PAUSE_MIN_RST;
        lim_pause_max = dpd_pkg::PAUSE_MAX_RST;
        lim_timeout   = dpd_pkg::TIMEOUT_RST;
        lim_glitch    = dpd_pkg::GLITCH_LIMIT_RST;
        for (int c = 0; c < N_CH; c++)
        begin
            ch_phase[c]       = dpd_pkg::PH_IDLE;
            ch_timer[c]       = '0;
            ch_pause_start[c] = '0;
            ch_glitch[c]      = '0;
        end
        marker_ms = '0;
    endtask

    task automatic detector_step(input sample_t s, output pulse_result_t r);
        logic [dpd_pkg::TIME_W-1:0]   tmr;
        logic [dpd_pkg::GLITCH_W-1:0] gl;
        logic [dpd_pkg::PHASE_W-1:0]  ph;
        r    = '0;
        r.ch = s.ch;
        if (int'(s.ch) < N_CH)
        begin
            tmr = ch_timer[s.ch];
            gl  = ch_glitch[s.ch];
            ph  = ch_phase[s.ch];
            if (s.hi && ph == dpd_pkg::PH_IDLE)
            begin
                tmr = s.now;
                ph  = dpd_pkg::PH_FIRST;
                gl  = '0;
            end
            if (since(s.now, tmr) > lim_timeout)
            begin
                tmr = '0;
                ph  = dpd_pkg::PH_IDLE;
                gl  = '0;
            end
            if ((ph == dpd_pkg::PH_FIRST || ph == dpd_pkg::PH_SECOND) && !s.hi
                && gl != dpd_pkg::GLITCH_MAX)
                gl = gl + 1'b1;
            if (s.hi && ph == dpd_pkg::PH_FIRST && since(s.now, tmr) > lim_first
                && gl < lim_glitch)
            begin
                ph        = dpd_pkg::PH_HELD;
                marker_ms = s.now;
                gl        = '0;
                tmr       = s.now;
                r.first   = 1'b1;
            end
            if (s.hi && ph == dpd_pkg::PH_HELD)
                tmr = s.now;
            if (!s.hi && ph == dpd_pkg::PH_HELD && since(s.now, tmr) > lim_pause_min)
            begin
                ph                   = dpd_pkg::PH_PAUSE;
                tmr                  = s.now;
                ch_pause_start[s.ch] = s.now;
            end
            if (!s.hi && ph == dpd_pkg::PH_PAUSE
                && since(s.now, ch_pause_start[s.ch]) < lim_pause_max)
                tmr = s.now;
            if (s.hi && ph == dpd_pkg::PH_PAUSE)
            begin
                tmr = s.now;
                ph  = dpd_pkg::PH_SECOND;
                gl  = '0;
            end
            if (s.hi && ph == dpd_pkg::PH_SECOND && since(s.now, tmr) > lim_second
                && gl < lim_glitch)
            begin
                gl    = '0;
                tmr   = '0;
                ph    = dpd_pkg::PH_IDLE;
                r.dbl = 1'b1;
            end
            ch_timer[s.ch]  = tmr;
            ch_glitch[s.ch] = gl;
            ch_phase[s.ch]  = ph;
            r.phase         = ph;
        end
        r.marker = marker_ms;
    endtask

    task automatic check_field(input string what, input logic [dpd_pkg::TIME_W-1:0] want, got);
        if (want !== got)
        begin
            err_count++;
            $display("t=%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // ---------------- stimulus helpers ----------------
    task automatic push_at(input int ch, input bit hi, input logic [dpd_pkg::TIME_W-1:0] t);
        sample_t s;
        s.ch = dpd_pkg::CH_W'(ch);
        s.hi = hi;
        s.now = t;
        pending_samples.push_back(s);
        samples_queued++;
        clock_ms = t;
    endtask

    task automatic push_after(input int ch, input bit hi, input logic [dpd_pkg::TIME_W-1:0] dt);
        push_at(ch, hi, clock_ms + dt);
    endtask

    task automatic emit_level(input int ch, input bit hi,
                              input logic [dpd_pkg::TIME_W-1:0] span, input bit glitchy);
        int n;
        logic [dpd_pkg::TIME_W-1:0] step;
        n    = $urandom_range(2, 6);
        step = span / n + 1;
        for (int i = 0; i < n; i++)
        begin
            push_after(ch, hi, step);
            if (glitchy && $urandom_range(0, 3) == 0)
                push_after(ch, !hi, $urandom_range(0, 3));
        end
    endtask

    task automatic emit_double(input int ch);
        emit_level(ch, 1'b1, lim_first + $urandom_range(1, 40), $urandom_range(0, 2) == 0);
        if ($urandom_range(0, 4) == 0)
            push_after($urandom_range(0, N_CH - 1), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 5));
        emit_level(ch, 1'b0, lim_pause_min + $urandom_range(1, 40), 1'b0);
        emit_level(ch, 1'b1, lim_second + $urandom_range(1, 40), $urandom_range(0, 2) == 0);
    endtask

    // long run of glitches drives the counter into saturation
    task automatic emit_storm(input int ch);
        push_after(ch, 1'b0, lim_timeout + 1);
        push_after(ch, 1'b1, 1);
        for (int i = 0; i < STORM_LEN; i++)
            push_after(ch, 1'b0, 0);
        push_after(ch, 1'b1, lim_first + 1);
    endtask

    task automatic random_phase(input int count, input bit with_storm);
        int target;
        int pick;
        int ch;
        target = samples_queued + count;
        if (with_storm)
            emit_storm($urandom_range(0, N_CH - 1));
        while (samples_queued < target)
        begin
            pick = $urandom_range(0, 9);
            ch   = $urandom_range(0, N_CH - 1);
            if (pick <= 6)
                emit_double(ch);
            else if (pick == 7)
                push_after(ch, 1'($urandom_range(0, 1)), $urandom_range(0, 300));
            else if (pick == 8)
            begin
                emit_level(ch, 1'b1, lim_first + $urandom_range(1, 40), 1'b1);
                if ($urandom_range(0, 1))
                    emit_level(ch, 1'b0, $urandom_range(0, 60), 1'b0);
                push_after(ch, 1'($urandom_range(0, 1)), lim_timeout + $urandom_range(1, 50));
            end
            else
            begin
                if ($urandom_range(0, 1))
                    clock_ms = $urandom();
                else
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
                push_after(ch, 1'($urandom_range(0, 1)), 0);
            end
        end
    endtask

    task automatic write_reg(input logic [dpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dpd_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            dpd_pkg::REG_FIRST_MIN:    lim_first     = val;
            dpd_pkg::REG_SECOND_MIN:   lim_second    = val;
            dpd_pkg::REG_PAUSE_MIN:    lim_pause_min = val;
            dpd_pkg::REG_PAUSE_MAX:    lim_pause_max = val;
            dpd_pkg::REG_TIMEOUT:      lim_timeout   = val;
            dpd_pkg::REG_GLITCH_LIMIT: lim_glitch    = val[dpd_pkg::GLITCH_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || in_busy || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // ---------------- sample driver ----------------
    always @(negedge clk)
    begin : sample_driver
        sample_t nxt;
        if (rst_n)
        begin
            if (in_fire_q)
            begin
                in_busy = 1'b0;
                tx_wait = stall_en ? $urandom_range(0, 3) : 0;
            end
            if (!in_busy)
            begin
                if (tx_wait > 0)
                    tx_wait--;
                else if (pending_samples.size() != 0)
                begin
                    nxt = pending_samples.pop_front();
                    s_axis_tdata <= {{(dpd_pkg::IN_TDATA_W - $bits(sample_t)){1'b0}}, nxt};
                    in_busy = 1'b1;
                end
            end
            s_axis_tvalid <= in_busy;
        end
    end

    // ---------------- result receiver ----------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire_q)
                rx_wait = stall_en ? $urandom_range(0, 3) : 0;
            else if (rx_wait > 0)
                rx_wait--;
            m_axis_tready <= (rx_wait == 0) && (hold_cnt == 0);
        end
    end

    // long output hold-off once the stream is under way
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready && samples_sent == HOLD_AT)
            hold_cnt <= HOLD_LEN;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    // ---------------- monitor and scoreboard ----------------
    always @(posedge clk)
    begin : monitor
        pulse_result_t got;
        pulse_result_t want;
        pulse_result_t pred;
        in_fire_q  <= s_axis_tvalid && s_axis_tready;
        out_fire_q <= m_axis_tvalid && m_axis_tready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(pulse_result_t)-1:0];
                if (expected_results.size() == 0)
                begin
                    err_count++;
                    $display("t=%0t unexpected result transaction: expected none, actual %0h",
                             $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("out_channel", dpd_pkg::TIME_W'(want.ch),
                                dpd_pkg::TIME_W'(got.ch));
                    check_field("first_confirmed", dpd_pkg::TIME_W'(want.first),
                                dpd_pkg::TIME_W'(got.first));
                    check_field("double_detected", dpd_pkg::TIME_W'(want.dbl),
                                dpd_pkg::TIME_W'(got.dbl));
                    check_field("marker_ms", want.marker, got.marker);
                    check_field("phase", dpd_pkg::TIME_W'(want.phase),
                                dpd_pkg::TIME_W'(got.phase));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                detector_step(s_axis_tdata[$bits(sample_t)-1:0], pred);
                expected_results.push_back(pred);
                samples_sent <= samples_sent + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("** double_pulse_detector: FAILED **");
            $finish;
        end
    end

    // ---------------- test sequence ----------------
    initial
    begin
        reset_model();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // channel 0: first pulse at the threshold, pause, glitch in second pulse, double
        push_at(0, 1'b1, 32'd100);
        push_at(0, 1'b1, 32'd140);
        push_at(0, 1'b1, 32'd141);
        push_at(0, 1'b0, 32'd150);
        push_at(0, 1'b0, 32'd191);
        push_at(0, 1'b0, 32'd192);
        push_at(0, 1'b1, 32'd300);
        push_at(0, 1'b0, 32'd320);
        push_at(0, 1'b1, 32'd350);
        push_at(0, 1'b1, 32'd351);
        // channel 1: first pulse runs into timeout
        push_at(1, 1'b1, 32'd400);
        push_at(1, 1'b1, 32'd1401);
        push_at(1, 1'b0, 32'd1402);
        // channel 2: start right after boot, pause runs into the timeout before any refresh
        push_at(2, 1'b1, 32'd5);
        push_at(2, 1'b1, 32'd50);
        push_at(2, 1'b0, 32'd120);
        push_at(2, 1'b0, 32'd1619);
        push_at(2, 1'b0, 32'd1621);
        push_at(2, 1'b0, 32'd2700);
        // channel 3: pulse across the time wrap
        push_at(3, 1'b1, 32'hFFFF_FFF0);
        push_at(3, 1'b1, 32'h0000_0019);
        push_at(3, 1'b1, 32'hFFFF_FFFF);
        clock_ms = 32'd3000;
        random_phase(250, 1'b0);
        wait_drained();

        // all limits at zero, no idling on either side
        stall_en = 1'b0;
        write_reg(dpd_pkg::REG_FIRST_MIN, '0);
        write_reg(dpd_pkg::REG_SECOND_MIN, '0);
        write_reg(dpd_pkg::REG_PAUSE_MIN, '0);
        write_reg(dpd_pkg::REG_PAUSE_MAX, '0);
        write_reg(dpd_pkg::REG_TIMEOUT, '0);
        write_reg(dpd_pkg::REG_GLITCH_LIMIT, 16'hA500);
        write_reg(REG_UNUSED_LO, 16'hFFFF);
        write_reg(REG_UNUSED_HI, 16'h1234);
        random_phase(100, 1'b0);
        wait_drained();

        // all limits at maximum
        stall_en = 1'b1;
        write_reg(dpd_pkg::REG_FIRST_MIN, 16'hFFFF);
        write_reg(dpd_pkg::REG_SECOND_MIN, 16'hFFFF);
        write_reg(dpd_pkg::REG_PAUSE_MIN, 16'hFFFF);
        write_reg(dpd_pkg::REG_PAUSE_MAX, 16'hFFFF);
        write_reg(dpd_pkg::REG_TIMEOUT, 16'hFFFF);
        write_reg(dpd_pkg::REG_GLITCH_LIMIT, 16'hFFFF);
        random_phase(150, 1'b1);
        wait_drained();

        // tight random limits, glitches matter
        write_reg(dpd_pkg::REG_FIRST_MIN, dpd_pkg::CFG_DATA_W'($urandom_range(0, 120)));
        write_reg(dpd_pkg::REG_SECOND_MIN, dpd_pkg::CFG_DATA_W'($urandom_range(0, 120)));
        write_reg(dpd_pkg::REG_PAUSE_MIN, dpd_pkg::CFG_DATA_W'($urandom_range(0, 120)));
        write_reg(dpd_pkg::REG_PAUSE_MAX, dpd_pkg::CFG_DATA_W'($urandom_range(50, 400)));
        write_reg(dpd_pkg::REG_TIMEOUT, dpd_pkg::CFG_DATA_W'($urandom_range(200, 800)));
        write_reg(dpd_pkg::REG_GLITCH_LIMIT, {8'($urandom()), 8'($urandom_range(1, 4))});
        random_phase(300, 1'b1);
        wait_drained();

        write_reg(dpd_pkg::REG_FIRST_MIN, dpd_pkg::FIRST_MIN_RST);
        write_reg(dpd_pkg::REG_SECOND_MIN, dpd_pkg::SECOND_MIN_RST);
        write_reg(dpd_pkg::REG_PAUSE_MIN, dpd_pkg::PAUSE_MIN_RST);
        write_reg(dpd_pkg::REG_PAUSE_MAX, dpd_pkg::PAUSE_MAX_RST);
        write_reg(dpd_pkg::REG_TIMEOUT, dpd_pkg::TIMEOUT_RST);
        write_reg(dpd_pkg::REG_GLITCH_LIMIT, {8'h5A, dpd_pkg::GLITCH_LIMIT_RST});
        random_phase(150, 1'b0);
        wait_drained();

        if (err_count == 0 && expected_results.size() == 0)
            $display("** double_pulse_detector: PASSED **");
        else
            $display("** double_pulse_detector: FAILED **");
        $finish;
    end

endmodule
